### sv/hzt_pkg.sv
// ----------------------------------------------------------------------------
// hzt_pkg
// Types, constants and codes shared by the heat zone tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hzt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [15:0] ONE_Q15      = 16'd32768;
   localparam logic [15:0] HOT_RESET    = 16'd22938;
   localparam logic [15:0] WARM_RESET   = 16'd9830;
   localparam logic [14:0] DECAY_RESET  = 15'd29491;
   localparam logic [14:0] BAND_RESET   = 15'd1638;
   localparam logic [14:0] DECAY_MIN    = 15'd16384;
   localparam logic [14:0] DECAY_MAX    = 15'd32735;
   localparam logic [14:0] BAND_MAX     = 15'd16384;
   localparam logic [15:0] HOT_BASE     = 16'd22938;
   localparam logic [15:0] HOT_SLOPE    = 16'd6554;
   localparam logic [15:0] HOT_CEIL     = 16'd29491;
   localparam logic [15:0] WARM_BASE    = 16'd9830;
   localparam logic [15:0] WARM_SLOPE   = 16'd4915;
   localparam logic [15:0] WARM_GAP     = 16'd1638;

   localparam logic [1:0] OP_UPSERT    = 2'd0;
   localparam logic [1:0] OP_REBALANCE = 2'd1;
   localparam logic [1:0] OP_PRESSURE  = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   localparam logic [1:0] ZONE_COLD = 2'd0;
   localparam logic [1:0] ZONE_WARM = 2'd1;
   localparam logic [1:0] ZONE_HOT  = 2'd2;

   localparam logic [2:0] ST_UPSERT_DONE = 3'd0;
   localparam logic [2:0] ST_MIGRATED    = 3'd1;
   localparam logic [2:0] ST_NO_MIGRATE  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
   localparam logic [2:0] ST_PRESSURE    = 3'd4;

   localparam logic [1:0] CSR_HOT   = 2'd0;
   localparam logic [1:0] CSR_WARM  = 2'd1;
   localparam logic [1:0] CSR_DECAY = 2'd2;
   localparam logic [1:0] CSR_BAND  = 2'd3;

   typedef struct packed {
      logic [63:0] key;
      logic [15:0] average;
      logic [31:0] bytes;
      logic [1:0]  zone;
   } entry_type;

   typedef struct packed {
      logic [63:0] result_id;
      logic [1:0]  old_zone;
      logic [1:0]  new_zone;
      logic [2:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [14:0] decay;
      logic [14:0] band;
      logic [15:0] live_hot;
      logic [15:0] live_warm;
   } cfg_type;

   typedef struct packed {
      logic        update;
      logic [15:0] hot;
      logic [15:0] warm;
   } live_upd_type;

endpackage

`default_nettype wire

### sv/hzt_req_if.sv
// ----------------------------------------------------------------------------
// hzt_req_if
// Request channel carrying one input item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hzt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] span_id;
   logic [15:0] temperature;
   logic [31:0] byte_count;
   logic [15:0] pressure_ratio;

   modport source (output valid, opcode, span_id, temperature, byte_count, pressure_ratio,
                   input ready);
   modport sink (input valid, opcode, span_id, temperature, byte_count, pressure_ratio,
                 output ready);
endinterface

`default_nettype wire

### sv/hzt_rsp_if.sv
// ----------------------------------------------------------------------------
// hzt_rsp_if
// Result channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hzt_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_id;
   logic [1:0]  old_zone;
   logic [1:0]  new_zone;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, result_id, old_zone, new_zone, status, last, input ready);
   modport sink (input valid, result_id, old_zone, new_zone, status, last, output ready);
endinterface

`default_nettype wire

### sv/heat_zone_tracker_top.sv
// An upsert reads and checks each slot in turn (one read and one check per slot), a
// rebalance does the same but may stall on results, a pressure update sets the thresholds.
// Throughput: one item at a time; the slot memory read port sets the scan rate.
// Reset: synchronous, active high; clears all slot valid bits and loads the register
// defaults into the live thresholds. No clearing pass is needed.
// ----------------------------------------------------------------------------
// heat_zone_tracker_top
// Configuration registers, live thresholds and the slot table sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heat_zone_tracker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   hzt_req_if.sink          req_bus,
   hzt_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [14:0]           decay_ff, band_ff;
   logic [15:0]           live_hot_ff, live_warm_ff;
   hzt_pkg::cfg_type      cfg;
   hzt_pkg::live_upd_type live_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_hot_ff  <= hzt_pkg::HOT_RESET;
         live_warm_ff <= hzt_pkg::WARM_RESET;
         decay_ff     <= hzt_pkg::DECAY_RESET;
         band_ff      <= hzt_pkg::BAND_RESET;
      end else begin
         if (live_upd.update) begin
            live_hot_ff  <= live_upd.hot;
            live_warm_ff <= live_upd.warm;
         end
         if (csr_we) begin
            unique case (csr_index)
               hzt_pkg::CSR_HOT:   live_hot_ff  <= csr_wdata;
               hzt_pkg::CSR_WARM:  live_warm_ff <= csr_wdata;
               hzt_pkg::CSR_DECAY: decay_ff     <= csr_wdata[14:0];
               default:            band_ff      <= csr_wdata[14:0];
            endcase
         end
      end
   end

   always_comb begin
      if (decay_ff < hzt_pkg::DECAY_MIN) cfg.decay = hzt_pkg::DECAY_MIN;
      else if (decay_ff > hzt_pkg::DECAY_MAX) cfg.decay = hzt_pkg::DECAY_MAX;
      else cfg.decay = decay_ff;
      cfg.band      = (band_ff > hzt_pkg::BAND_MAX) ? hzt_pkg::BAND_MAX : band_ff;
      cfg.live_hot  = live_hot_ff;
      cfg.live_warm = live_warm_ff;
   end

   hzt_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .cfg      (cfg),
      .live_upd (live_upd)
   );

endmodule

`default_nettype wire

### sv/hzt_classify.sv
// ----------------------------------------------------------------------------
// hzt_classify
// Zone classifier with a hysteresis band around the live thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hzt_classify (
   input  wire hzt_pkg::cfg_type cfg,
   input  wire logic [1:0]       zone,
   input  wire logic [15:0]      average,
   output logic [1:0]            new_zone
);

   logic signed [18:0] a_s, h_s, w_s, b_s;
   logic signed [18:0] h_lo, h_hi, w_lo, w_hi;

   always_comb begin
      a_s  = signed'({3'b000, average});
      h_s  = signed'({3'b000, cfg.live_hot});
      w_s  = signed'({3'b000, cfg.live_warm});
      b_s  = signed'({4'b0000, cfg.band});
      h_lo = h_s - b_s;
      h_hi = h_s + b_s;
      w_lo = w_s - b_s;
      w_hi = w_s + b_s;
      priority if (zone == hzt_pkg::ZONE_HOT) begin
         if (a_s < h_lo) begin
            new_zone = (a_s >= w_lo) ? hzt_pkg::ZONE_WARM : hzt_pkg::ZONE_COLD;
         end else begin
            new_zone = hzt_pkg::ZONE_HOT;
         end
      end else if (zone == hzt_pkg::ZONE_WARM) begin
         if (a_s >= h_hi) new_zone = hzt_pkg::ZONE_HOT;
         else if (a_s < w_lo) new_zone = hzt_pkg::ZONE_COLD;
         else new_zone = hzt_pkg::ZONE_WARM;
      end else begin
         if (a_s >= h_hi) new_zone = hzt_pkg::ZONE_HOT;
         else if (a_s >= w_hi) new_zone = hzt_pkg::ZONE_WARM;
         else new_zone = hzt_pkg::ZONE_COLD;
      end
   end

endmodule

`default_nettype wire

### sv/hzt_seq.sv
// ----------------------------------------------------------------------------
// hzt_seq
// Sequencer with the slot memory, the shared multiplier and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hzt_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hzt_req_if.sink                    req,
   hzt_rsp_if.source                  rsp,
   input  wire hzt_pkg::cfg_type      cfg,
   output hzt_pkg::live_upd_type      live_upd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CK, S_SCAN_END, S_EMA_A, S_EMA_B, S_UPD,
      S_REB_RD, S_REB_CK, S_FLUSH, S_PR_H, S_PR_W, S_EMIT
   } state_type;

   state_type                   state_ff;
   logic [hzt_pkg::IDX_W-1:0]   cnt_ff, slot_ff, free_ff;
   logic                        found_ff, free_vld_ff;
   logic [hzt_pkg::ENTRIES-1:0] valid_ff;
   hzt_pkg::entry_type          slot_mem [hzt_pkg::ENTRIES];
   hzt_pkg::entry_type          rd_q_ff, ent_ff;
   logic [63:0]                 id_ff;
   logic [15:0]                 temp_ff, pr_ff, avg_ff, hot_ff;
   logic [31:0]                 bytes_ff, acc_ff;
   hzt_pkg::result_type         out_ff, pend_ff, res_ff;
   logic                        out_vld_ff, pend_vld_ff;
   hzt_pkg::live_upd_type       live_ff;

   logic [15:0]                 mul_a, mul_b;
   logic [31:0]                 prod;
   logic [32:0]                 ema_sum;
   logic [16:0]                 hot_sum, warm_sum;
   logic [15:0]                 warm_cap;
   logic [15:0]                 comp;
   logic [1:0]                  cls_zone, cls_new;
   logic [15:0]                 cls_avg;
   logic                        out_free, last_slot, cur_valid, chg, load_out;

   hzt_classify u_classify (
      .cfg      (cfg),
      .zone     (cls_zone),
      .average  (cls_avg),
      .new_zone (cls_new)
   );

   always_comb begin
      comp = hzt_pkg::ONE_Q15 - {1'b0, cfg.decay};
      unique case (state_ff)
         S_EMA_A: begin mul_a = avg_ff;  mul_b = {1'b0, cfg.decay}; end
         S_EMA_B: begin mul_a = temp_ff; mul_b = comp; end
         S_PR_H:  begin mul_a = pr_ff;   mul_b = hzt_pkg::HOT_SLOPE; end
         default: begin mul_a = pr_ff;   mul_b = hzt_pkg::WARM_SLOPE; end
      endcase
      prod     = mul_a * mul_b;
      ema_sum  = {1'b0, acc_ff} + {1'b0, prod};
      hot_sum  = {1'b0, hzt_pkg::HOT_BASE} + {2'b00, prod[29:15]};
      warm_sum = {1'b0, hzt_pkg::WARM_BASE} + {2'b00, prod[29:15]};
      warm_cap = hot_ff - hzt_pkg::WARM_GAP;
      if (state_ff == S_REB_CK) begin
         cls_zone = rd_q_ff.zone;
         cls_avg  = rd_q_ff.average;
      end else begin
         cls_zone = ent_ff.zone;
         cls_avg  = avg_ff;
      end
      out_free  = !out_vld_ff || rsp.ready;
      last_slot = (cnt_ff == hzt_pkg::IDX_W'(hzt_pkg::ENTRIES - 1));
      cur_valid = valid_ff[cnt_ff];
      chg       = cur_valid && (cls_new != rd_q_ff.zone);
      load_out  = ((state_ff == S_UPD) && out_free) ||
                  ((state_ff == S_REB_CK) && chg && pend_vld_ff && out_free) ||
                  (((state_ff == S_FLUSH) || (state_ff == S_EMIT)) && out_free);
   end

   // Slot memory: at most one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      rd_q_ff <= slot_mem[cnt_ff];
      if (state_ff == S_UPD && out_free) begin
         slot_mem[slot_ff] <= '{key: id_ff, average: avg_ff, bytes: bytes_ff, zone: cls_new};
      end else if (state_ff == S_REB_CK && chg && (!pend_vld_ff || out_free)) begin
         slot_mem[cnt_ff] <= '{key: rd_q_ff.key, average: rd_q_ff.average,
                               bytes: rd_q_ff.bytes, zone: cls_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         out_vld_ff     <= 1'b0;
         pend_vld_ff    <= 1'b0;
         live_ff.update <= 1'b0;
      end else begin
         live_ff.update <= (state_ff == S_PR_W);
         if (load_out) out_vld_ff <= 1'b1;
         else if (rsp.ready) out_vld_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  id_ff       <= req.span_id;
                  temp_ff     <= (req.temperature > hzt_pkg::ONE_Q15) ?
                                 hzt_pkg::ONE_Q15 : req.temperature;
                  pr_ff       <= (req.pressure_ratio > hzt_pkg::ONE_Q15) ?
                                 hzt_pkg::ONE_Q15 : req.pressure_ratio;
                  bytes_ff    <= req.byte_count;
                  cnt_ff      <= '0;
                  found_ff    <= 1'b0;
                  free_vld_ff <= 1'b0;
                  pend_vld_ff <= 1'b0;
                  unique case (req.opcode)
                     hzt_pkg::OP_UPSERT:    state_ff <= S_SCAN_RD;
                     hzt_pkg::OP_REBALANCE: state_ff <= S_REB_RD;
                     hzt_pkg::OP_PRESSURE:  state_ff <= S_PR_H;
                     default:               state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CK;
            S_SCAN_CK: begin
               if (cur_valid && !found_ff && rd_q_ff.key == id_ff) begin
                  found_ff <= 1'b1;
                  slot_ff  <= cnt_ff;
                  ent_ff   <= rd_q_ff;
               end
               if (!cur_valid && !free_vld_ff) begin
                  free_vld_ff <= 1'b1;
                  free_ff     <= cnt_ff;
               end
               if (last_slot) begin
                  state_ff <= S_SCAN_END;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_END: begin
               if (found_ff) begin
                  if (ent_ff.average == '0 && ent_ff.bytes == '0) begin
                     avg_ff   <= temp_ff;
                     state_ff <= S_UPD;
                  end else begin
                     avg_ff   <= ent_ff.average;
                     state_ff <= S_EMA_A;
                  end
               end else if (free_vld_ff) begin
                  slot_ff  <= free_ff;
                  ent_ff   <= '{key: id_ff, average: '0, bytes: '0, zone: hzt_pkg::ZONE_COLD};
                  avg_ff   <= temp_ff;
                  state_ff <= S_UPD;
               end else begin
                  res_ff   <= '{result_id: id_ff, old_zone: hzt_pkg::ZONE_COLD,
                                new_zone: hzt_pkg::ZONE_COLD,
                                status: hzt_pkg::ST_TABLE_FULL, last: 1'b1};
                  state_ff <= S_EMIT;
               end
            end
            S_EMA_A: begin
               acc_ff   <= prod;
               state_ff <= S_EMA_B;
            end
            S_EMA_B: begin
               avg_ff   <= ema_sum[30:15];
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (out_free) begin
                  valid_ff[slot_ff] <= 1'b1;
                  out_ff     <= '{result_id: id_ff, old_zone: ent_ff.zone, new_zone: cls_new,
                                  status: hzt_pkg::ST_UPSERT_DONE, last: 1'b1};
                  state_ff   <= S_IDLE;
               end
            end
            S_REB_RD: state_ff <= S_REB_CK;
            S_REB_CK: begin
               if (!(chg && pend_vld_ff && !out_free)) begin
                  if (chg) begin
                     if (pend_vld_ff) begin
                        out_ff <= pend_ff;
                     end
                     pend_ff     <= '{result_id: rd_q_ff.key, old_zone: rd_q_ff.zone,
                                      new_zone: cls_new, status: hzt_pkg::ST_MIGRATED,
                                      last: 1'b0};
                     pend_vld_ff <= 1'b1;
                  end
                  if (last_slot) begin
                     state_ff <= S_FLUSH;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= S_REB_RD;
                  end
               end
            end
            S_FLUSH: begin
               if (out_free) begin
                  if (pend_vld_ff) begin
                     out_ff <= '{result_id: pend_ff.result_id, old_zone: pend_ff.old_zone,
                                 new_zone: pend_ff.new_zone, status: pend_ff.status,
                                 last: 1'b1};
                  end else begin
                     out_ff <= '{result_id: '0, old_zone: hzt_pkg::ZONE_COLD,
                                 new_zone: hzt_pkg::ZONE_COLD,
                                 status: hzt_pkg::ST_NO_MIGRATE, last: 1'b1};
                  end
                  pend_vld_ff <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end
            S_PR_H: begin
               hot_ff   <= (hot_sum > {1'b0, hzt_pkg::HOT_CEIL}) ?
                           hzt_pkg::HOT_CEIL : hot_sum[15:0];
               state_ff <= S_PR_W;
            end
            S_PR_W: begin
               live_ff.hot    <= hot_ff;
               live_ff.warm   <= (warm_sum > {1'b0, warm_cap}) ? warm_cap : warm_sum[15:0];
               res_ff   <= '{result_id: '0, old_zone: hzt_pkg::ZONE_COLD,
                             new_zone: hzt_pkg::ZONE_COLD,
                             status: hzt_pkg::ST_PRESSURE, last: 1'b1};
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  out_ff     <= res_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = out_vld_ff;
   assign rsp.result_id = out_ff.result_id;
   assign rsp.old_zone  = out_ff.old_zone;
   assign rsp.new_zone  = out_ff.new_zone;
   assign rsp.status    = out_ff.status;
   assign rsp.last      = out_ff.last;
   assign live_upd      = live_ff;

`ifndef SYNTHESIS
   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) >= $past($countones(valid_ff))))
      else $error("slot valid count decreased");
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_vld_ff)
      else $error("pending migration left behind");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp.ready) |=> $stable(out_ff))
      else $error("waiting result overwritten");
   a_live_order: assert property (@(posedge clock) disable iff (reset)
      live_ff.update |-> (live_ff.warm <= live_ff.hot - hzt_pkg::WARM_GAP))
      else $error("live warm threshold above its cap");
`endif

endmodule

`default_nettype wire

### test/hzt_zone_checker.sv
// ----------------------------------------------------------------------------
// hzt_zone_checker
// Watches the request and result channels of the heat zone tracker, predicts
// the results of every accepted request from its own copy of the slot table,
// thresholds and registers, and compares each whole result transfer with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hzt_zone_checker
   import hzt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [63:0] req_span_id,
   input  wire logic [15:0] req_temperature,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [15:0] req_pressure_ratio,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire result_type  rsp_result,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               errors,
   output int               pending
);

   logic        span_used [ENTRIES];
   logic [63:0] span_key  [ENTRIES];
   logic [15:0] span_avg  [ENTRIES];
   logic [31:0] span_bytes[ENTRIES];
   logic [1:0]  span_zone [ENTRIES];
   logic [15:0] hot_now, warm_now;
   logic [14:0] decay_reg, band_reg;
   result_type  zone_results[$];

   assign pending = zone_results.size();

   function automatic logic [1:0] next_zone(logic [1:0] zone, logic [15:0] avg);
      int b, h, w, a;
      b = (band_reg > BAND_MAX) ? int'(BAND_MAX) : int'(band_reg);
      h = int'(hot_now);
      w = int'(warm_now);
      a = int'(avg);
      if (zone == ZONE_HOT) begin
         if (a < h - b) return (a >= w - b) ? ZONE_WARM : ZONE_COLD;
         return ZONE_HOT;
      end
      if (zone == ZONE_WARM) begin
         if (a >= h + b) return ZONE_HOT;
         if (a < w - b) return ZONE_COLD;
         return ZONE_WARM;
      end
      if (a >= h + b) return ZONE_HOT;
      if (a >= w + b) return ZONE_WARM;
      return ZONE_COLD;
   endfunction

   task automatic predict_transfer();
      int hit, spare, n;
      logic [15:0] t, ph, pw;
      logic [16:0] p;
      longint unsigned d, acc;
      logic [1:0] oz, nz;
      result_type r;
      case (req_opcode)
         OP_UPSERT: begin
            hit = -1;
            spare = -1;
            t = (req_temperature > ONE_Q15) ? ONE_Q15 : req_temperature;
            for (int i = 0; i < ENTRIES; i++) begin
               if (span_used[i]) begin
                  if (hit < 0 && span_key[i] == req_span_id) hit = i;
               end else if (spare < 0) begin
                  spare = i;
               end
            end
            if (hit < 0 && spare < 0) begin
               zone_results.insert(zone_results.size(),
                                   '{req_span_id, ZONE_COLD, ZONE_COLD, ST_TABLE_FULL, 1'b1});
            end else begin
               if (hit < 0) begin
                  hit = spare;
                  span_used[hit] = 1'b1;
                  span_key[hit] = req_span_id;
                  span_avg[hit] = '0;
                  span_bytes[hit] = '0;
                  span_zone[hit] = ZONE_COLD;
               end
               if (span_avg[hit] == 0 && span_bytes[hit] == 0) begin
                  span_avg[hit] = t;
               end else begin
                  d = decay_reg;
                  if (d < DECAY_MIN) d = DECAY_MIN;
                  if (d > DECAY_MAX) d = DECAY_MAX;
                  acc = (longint'(span_avg[hit]) * d + longint'(t) * (32768 - d)) >> 15;
                  span_avg[hit] = acc[15:0];
               end
               span_bytes[hit] = req_byte_count;
               oz = span_zone[hit];
               nz = next_zone(oz, span_avg[hit]);
               span_zone[hit] = nz;
               zone_results.insert(zone_results.size(),
                                   '{req_span_id, oz, nz, ST_UPSERT_DONE, 1'b1});
            end
         end
         OP_REBALANCE: begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (span_used[i]) begin
                  oz = span_zone[i];
                  nz = next_zone(oz, span_avg[i]);
                  if (nz != oz) begin
                     zone_results.insert(zone_results.size(),
                                         '{span_key[i], oz, nz, ST_MIGRATED, 1'b0});
                     span_zone[i] = nz;
                     n++;
                  end
               end
            end
            if (n == 0) begin
               zone_results.insert(zone_results.size(),
                                   '{64'd0, ZONE_COLD, ZONE_COLD, ST_NO_MIGRATE, 1'b1});
            end else begin
               r = zone_results.pop_back();
               r.last = 1'b1;
               zone_results.insert(zone_results.size(), r);
            end
         end
         OP_PRESSURE: begin
            p = (req_pressure_ratio > ONE_Q15) ? 17'(ONE_Q15) : 17'(req_pressure_ratio);
            ph = HOT_BASE + 16'((32'(HOT_SLOPE) * p) >> 15);
            pw = WARM_BASE + 16'((32'(WARM_SLOPE) * p) >> 15);
            if (ph > HOT_CEIL) ph = HOT_CEIL;
            if (pw > ph - WARM_GAP) pw = ph - WARM_GAP;
            hot_now = ph;
            warm_now = pw;
            zone_results.insert(zone_results.size(),
                                '{64'd0, ZONE_COLD, ZONE_COLD, ST_PRESSURE, 1'b1});
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) span_used[i] = 1'b0;
         hot_now = HOT_RESET;
         warm_now = WARM_RESET;
         decay_reg = DECAY_RESET;
         band_reg = BAND_RESET;
         zone_results.delete();
         errors <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (zone_results.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected result transfer: %p", rsp_result);
            end else begin
               want = zone_results.pop_front();
               if (rsp_result !== want) begin
                  errors <= errors + 1;
                  if (errors < 10) $display("result mismatch: expected %p, got %p", want,
                                            rsp_result);
               end
            end
         end
         if (req_valid && req_ready) predict_transfer();
         if (csr_we) begin
            case (csr_index)
               CSR_HOT: begin
                  hot_now = csr_wdata;
               end
               CSR_WARM: begin
                  warm_now = csr_wdata;
               end
               CSR_DECAY: begin
                  decay_reg = csr_wdata[14:0];
               end
               default: begin
                  band_reg = csr_wdata[14:0];
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### test/heat_zone_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// heat_zone_tracker_top_tb
// Drives directed and random upsert, rebalance, pressure and unused-opcode requests through
// several register settings, with random idling and one long result hold-off,
// and reports the verdict of the zone checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heat_zone_tracker_top_tb;
   import hzt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_HOT;
   logic [15:0] csr_wdata = '0;
   logic        calm = 1'b0;
   logic        hold_off = 1'b0;
   logic        feeding = 1'b1;
   int          errors, pending;
   logic [63:0] known_ids[$];

   hzt_req_if req_bus();
   hzt_rsp_if rsp_bus();

   heat_zone_tracker_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus.sink),
      .rsp_bus  (rsp_bus.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   hzt_zone_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_opcode        (req_bus.opcode),
      .req_span_id       (req_bus.span_id),
      .req_temperature   (req_bus.temperature),
      .req_byte_count    (req_bus.byte_count),
      .req_pressure_ratio(req_bus.pressure_ratio),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_result        ({rsp_bus.result_id, rsp_bus.old_zone, rsp_bus.new_zone,
                           rsp_bus.status, rsp_bus.last}),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .errors            (errors),
      .pending           (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_UPSERT;
      req_bus.span_id = '0;
      req_bus.temperature = '0;
      req_bus.byte_count = '0;
      req_bus.pressure_ratio = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= calm || ($urandom_range(99) >= 30);
   end

   task automatic send_item(logic [1:0] op, logic [63:0] id, logic [15:0] temp,
                            logic [31:0] bytes, logic [15:0] ratio);
      while (!calm && $urandom_range(99) < 30) @(posedge clock);
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.span_id <= id;
      req_bus.temperature <= temp;
      req_bus.byte_count <= bytes;
      req_bus.pressure_ratio <= ratio;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending != 0) @(posedge clock);
      repeat (2 * ENTRIES + 20) @(posedge clock);
   endtask

   task automatic random_upserts(int count);
      logic [63:0] id;
      logic [1:0]  op;
      for (int n = 0; n < count; n++) begin
         op = OP_UPSERT;
         case ($urandom_range(19))
            0, 1: op = OP_REBALANCE;
            2: op = OP_PRESSURE;
            3: op = OP_UNUSED;
            default: begin
            end
         endcase
         if (known_ids.size() > 0 && $urandom_range(99) < 60) begin
            id = known_ids[$urandom_range(known_ids.size() - 1)];
         end else begin
            id = {$urandom, $urandom};
            known_ids.insert(known_ids.size(), id);
         end
         send_item(op, id, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
                   ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_REBALANCE, '0, '0, '0, '0);
      send_item(OP_UPSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send_item(OP_UPSERT, 64'd0, 16'd0, 32'd0, '0);
      send_item(OP_UPSERT, 64'd0, 16'd30000, 32'd0, '0);
      send_item(OP_UPSERT, 64'd0, 16'd0, 32'd5, '0);
      send_item(OP_UPSERT, 64'h5555_AAAA_5555_AAAA, 16'd12000, 32'h5555_5555, '0);
      send_item(OP_UPSERT, 64'h5555_AAAA_5555_AAAA, 16'd32768, 32'hAAAA_AAAA, '0);
      send_item(OP_PRESSURE, '0, '0, '0, 16'hFFFF);
      send_item(OP_REBALANCE, '0, '0, '0, '0);
      send_item(OP_PRESSURE, '0, '0, '0, 16'd0);
      send_item(OP_REBALANCE, '0, '0, '0, '0);
      send_item(OP_PRESSURE, '0, '0, '0, 16'd16384);
      send_item(OP_UNUSED, 64'h1234, 16'd100, 32'd7, 16'd200);
      for (int i = 0; i < ENTRIES + 2; i++)
         send_item(OP_UPSERT, 64'h100 + i, 16'($urandom_range(32768)), 32'(i + 1), '0);
      send_item(OP_REBALANCE, '0, '0, '0, '0);

      hold_off <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         repeat (5) send_item(OP_PRESSURE, '0, '0, '0, 16'($urandom_range(32768)));
      join
      drain_results();

      write_reg(CSR_HOT, 16'd0);
      write_reg(CSR_WARM, 16'd0);
      write_reg(CSR_DECAY, 16'd0);
      write_reg(CSR_BAND, 16'd0);
      send_item(OP_REBALANCE, '0, '0, '0, '0);
      send_item(OP_UPSERT, 64'h103, 16'd0, 32'd1, '0);
      drain_results();
      write_reg(CSR_HOT, 16'hFFFF);
      write_reg(CSR_WARM, 16'd32768);
      write_reg(CSR_DECAY, 16'h7FFF);
      write_reg(CSR_BAND, 16'h7FFF);
      send_item(OP_REBALANCE, '0, '0, '0, '0);
      send_item(OP_UPSERT, 64'h104, 16'd1, 32'd1, '0);
      drain_results();

      reset_table_free: begin
      end
      for (int phase = 0; phase < 3; phase++) begin
         write_reg(CSR_HOT, 16'($urandom_range(32768)));
         write_reg(CSR_WARM, 16'($urandom_range(20000)));
         write_reg(CSR_DECAY, 16'($urandom_range(16384, 32767)));
         write_reg(CSR_BAND, 16'($urandom_range(16384)));
         calm <= (phase == 1);
         random_upserts(20);
         drain_results();
      end

      if (errors == 0) $display("heat_zone_tracker_top_tb OK");
      else $display("heat_zone_tracker_top_tb NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("heat_zone_tracker_top_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
